>>> hdl/imhq_pkg.sv
package imhq_pkg;

	localparam int HEAP_CAPACITY = 1024;
	localparam int IDX_W = $clog2(HEAP_CAPACITY);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP = 2'd1;
	localparam logic [1:0] MODE_UPDATE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] value;
		logic signed [31:0] weight;
		logic [9:0] handle;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] new_handle;
		logic [31:0] top_value;
		logic signed [31:0] top_weight;
	} out_item_t;

endpackage

>>> hdl/indexed_max_heap_queue.sv
// Indexed max-heap priority queue with handles.
// A rejected or trivial beat presents its result after the lookup and start states;
// a sift adds a pass per level, going up or going down, and a pop first fetches
// the top entry and moves the last one to the root.
// One beat at a time: in_stall is held until the result beat has been taken.
// Reset clears counters and the sequencer; memories are not cleared.
module indexed_max_heap_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input imhq_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output imhq_pkg::out_item_t out_data
);

	localparam int IW = imhq_pkg::IDX_W;
	localparam int CW = imhq_pkg::CNT_W;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_LOOK = 10'b0000000010,
		S_START = 10'b0000000100,
		S_RD_A = 10'b0000001000,
		S_RD_B = 10'b0000010000,
		S_RD_C = 10'b0000100000,
		S_CMP = 10'b0001000000,
		S_SWAP = 10'b0010000000,
		S_POPMV = 10'b0100000000,
		S_OUT = 10'b1000000000
	} state_t;

	state_t state_q;
	imhq_pkg::in_item_t req_q;
	imhq_pkg::out_item_t res_q;

	// heap slot -> handle, handle -> weight/payload/position/live, freed stack
	logic [IW-1:0] slots_mem [imhq_pkg::HEAP_CAPACITY];
	logic [31:0] wgt_mem [imhq_pkg::HEAP_CAPACITY];
	logic [31:0] pay_mem [imhq_pkg::HEAP_CAPACITY];
	logic [IW-1:0] pos_mem [imhq_pkg::HEAP_CAPACITY];
	logic [IW-1:0] free_mem [imhq_pkg::HEAP_CAPACITY];
	logic live_mem [imhq_pkg::HEAP_CAPACITY];

	logic [CW-1:0] count_q, free_cnt_q, fresh_q;
	logic up_q;
	logic [IW-1:0] cur_q, par_q, chl_q, chr_q, pick_q;
	logic [IW-1:0] h_cur_q, h_oth_q, h_r_q;
	logic [31:0] k_cur_q, k_oth_q;
	logic has_r_q;
	logic [1:0] phase_q;

	// read ports (registered)
	logic [IW-1:0] slot_rd_q, free_rd_q, pos_rd_q;
	logic [31:0] wgt_rd_q, pay_rd_q;
	logic live_rd_q;
	logic [IW-1:0] slot_ra, wgt_ra;

	logic [CW:0] left_w;
	logic [CW-1:0] cur_x;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;
	assign cur_x = {1'b0, cur_q};
	assign left_w = {cur_x, 1'b1};

	// shared memory read addresses
	always_comb begin
		slot_ra = cur_q;
		wgt_ra = h_cur_q;
		case (state_q)
			S_LOOK: begin
				slot_ra = '0;
				wgt_ra = req_q.handle[IW-1:0];
			end
			S_RD_A: begin
				slot_ra = up_q ? par_q : chl_q;
				wgt_ra = h_cur_q;
			end
			S_RD_B: begin
				slot_ra = chr_q;
				wgt_ra = slot_rd_q;
			end
			S_RD_C: begin
				slot_ra = chr_q;
				wgt_ra = slot_rd_q;
			end
			S_CMP: begin
				slot_ra = cur_q;
				wgt_ra = h_r_q;
			end
			default: begin
				slot_ra = cur_q;
				wgt_ra = h_cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		slot_rd_q <= slots_mem[slot_ra];
		wgt_rd_q <= wgt_mem[wgt_ra];
		pay_rd_q <= pay_mem[wgt_ra];
		pos_rd_q <= pos_mem[wgt_ra];
		live_rd_q <= live_mem[wgt_ra];
		free_rd_q <= free_mem[free_cnt_q[IW-1:0] - 1'b1];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			free_cnt_q <= '0;
			fresh_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						res_q <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// memories now present root and handle reads next cycle
					phase_q <= 2'd0;
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_OUT;
					case (req_q.mode)
						imhq_pkg::MODE_PUSH: begin
							if (count_q[IW]) begin
								res_q.status <= imhq_pkg::ST_FULL;
							end else begin
								logic [IW-1:0] h;
								if (free_cnt_q != '0) begin
									h = free_rd_q;
									free_cnt_q <= free_cnt_q - 1'b1;
								end else begin
									h = fresh_q[IW-1:0];
									fresh_q <= fresh_q + 1'b1;
								end
								pay_mem[h] <= req_q.value;
								wgt_mem[h] <= req_q.weight;
								live_mem[h] <= 1'b1;
								slots_mem[count_q[IW-1:0]] <= h;
								pos_mem[h] <= count_q[IW-1:0];
								count_q <= count_q + 1'b1;
								res_q.new_handle <= h;
								h_cur_q <= h;
								k_cur_q <= req_q.weight ^ 32'h8000_0000;
								cur_q <= count_q[IW-1:0];
								par_q <= (count_q[IW-1:0] - 1'b1) >> 1;
								up_q <= 1'b1;
								if (count_q != '0) state_q <= S_RD_A;
							end
						end
						imhq_pkg::MODE_POP: begin
							if (count_q == '0) begin
								res_q.status <= imhq_pkg::ST_EMPTY;
							end else if (phase_q == 2'd0) begin
								// root handle read in S_LOOK; fetch its entry
								h_cur_q <= slot_rd_q;
								phase_q <= 2'd1;
								state_q <= S_POPMV;
							end
						end
						imhq_pkg::MODE_UPDATE: begin
							// handles at or above the fresh count were never issued
							if (!(({1'b0, req_q.handle[IW-1:0]} < fresh_q) && live_rd_q)) begin
								res_q.status <= imhq_pkg::ST_BAD_HANDLE;
							end else if ((wgt_rd_q ^ 32'h8000_0000) !=
									(req_q.weight ^ 32'h8000_0000)) begin
								wgt_mem[req_q.handle[IW-1:0]] <= req_q.weight;
								h_cur_q <= req_q.handle[IW-1:0];
								k_cur_q <= req_q.weight ^ 32'h8000_0000;
								cur_q <= pos_rd_q;
								par_q <= (pos_rd_q - 1'b1) >> 1;
								chl_q <= {pos_rd_q[IW-2:0], 1'b1};
								chr_q <= {pos_rd_q[IW-2:0], 1'b0} + 2'd2;
								up_q <= ($signed(req_q.weight) > $signed(wgt_rd_q));
								if ($signed(req_q.weight) > $signed(wgt_rd_q)) begin
									if (pos_rd_q != '0) state_q <= S_RD_A;
								end else begin
									state_q <= S_RD_A;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_POPMV: begin
					// phase 1: read popped entry; phase 2: take its result, free it; phase 3: move last to root
					if (phase_q == 2'd1) begin
						phase_q <= 2'd2;
						cur_q <= count_q[IW-1:0] - 1'b1;
					end else if (phase_q == 2'd2) begin
						res_q.top_value <= pay_rd_q;
						res_q.top_weight <= wgt_rd_q;
						live_mem[h_cur_q] <= 1'b0;
						if (!free_cnt_q[IW]) begin
							free_mem[free_cnt_q[IW-1:0]] <= h_cur_q;
							free_cnt_q <= free_cnt_q + 1'b1;
						end
						count_q <= count_q - 1'b1;
						phase_q <= 2'd3;
					end else begin
						phase_q <= 2'd0;
						if (count_q == '0) begin
							state_q <= S_OUT;
						end else begin
							slots_mem[0] <= slot_rd_q;
							pos_mem[slot_rd_q] <= '0;
							h_cur_q <= slot_rd_q;
							cur_q <= '0;
							chl_q <= {{(IW-1){1'b0}}, 1'b1};
							chr_q <= {{(IW-2){1'b0}}, 2'd2};
							up_q <= 1'b0;
							state_q <= S_RD_C;
						end
					end
				end
				S_RD_C: begin
					// fetch key of the element now at the sift slot
					state_q <= S_RD_A;
					phase_q <= 2'd1;
				end
				S_RD_A: begin
					if (phase_q == 2'd1) k_cur_q <= wgt_rd_q ^ 32'h8000_0000;
					phase_q <= 2'd0;
					if (!up_q && ({1'b0, left_w} >= {2'b0, count_q})) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD_B;
					end
				end
				S_RD_B: begin
					// other slot handle is in slot_rd_q; its weight arrives next
					h_oth_q <= slot_rd_q;
					pick_q <= up_q ? par_q : chl_q;
					has_r_q <= ({1'b0, left_w} + 1'b1) < {2'b0, count_q};
					state_q <= S_CMP;
				end
				S_CMP: begin
					logic [31:0] ko;
					ko = wgt_rd_q ^ 32'h8000_0000;
					if (phase_q == 2'd0) begin
						k_oth_q <= ko;
						if (!up_q && has_r_q) begin
							// hold right child's handle, then read its weight
							h_r_q <= slot_rd_q;
							phase_q <= 2'd2;
							state_q <= S_CMP;
						end else begin
							phase_q <= 2'd3;
						end
					end else if (phase_q == 2'd2) begin
						phase_q <= 2'd1;
					end else if (phase_q == 2'd1) begin
						if (k_oth_q < ko) begin
							k_oth_q <= ko;
							h_oth_q <= h_r_q;
							pick_q <= chr_q;
						end
						phase_q <= 2'd3;
					end else begin
						phase_q <= 2'd0;
						if (up_q ? (k_cur_q > k_oth_q) : (k_cur_q < k_oth_q))
							state_q <= S_SWAP;
						else
							state_q <= S_OUT;
					end
				end
				S_SWAP: begin
					logic [IW-1:0] np;
					np = pick_q;
					slots_mem[cur_q] <= h_oth_q;
					pos_mem[h_oth_q] <= cur_q;
					slots_mem[np] <= h_cur_q;
					pos_mem[h_cur_q] <= np;
					cur_q <= np;
					par_q <= (np - 1'b1) >> 1;
					chl_q <= {np[IW-2:0], 1'b1};
					chr_q <= {np[IW-2:0], 1'b0} + 2'd2;
					if (up_q && np == '0) state_q <= S_OUT;
					else state_q <= S_RD_A;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> dv/tb_indexed_max_heap_queue.sv
module tb_indexed_max_heap_queue;

	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [1:0] MODE_NONE = 2'd3;

	// Heap predictor and store of expected result beats
	class heap_scoreboard;
		logic signed [31:0] weight_of [imhq_pkg::HEAP_CAPACITY];
		logic [31:0] payload_of [imhq_pkg::HEAP_CAPACITY];
		int slot_handle [imhq_pkg::HEAP_CAPACITY];
		int slot_of [imhq_pkg::HEAP_CAPACITY];
		bit live [imhq_pkg::HEAP_CAPACITY];
		int count;
		int free_stack [imhq_pkg::HEAP_CAPACITY];
		int free_count;
		int fresh;
		imhq_pkg::out_item_t expected_q [$];
		int errors;
		int checked;

		function new();
			for (int i = 0; i < imhq_pkg::HEAP_CAPACITY; i++) live[i] = 0;
			count = 0;
			free_count = 0;
			fresh = 0;
			errors = 0;
			checked = 0;
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void place(int slot, int h);
			slot_handle[slot] = h;
			slot_of[h] = slot;
		endfunction

		function void swap(int a, int b);
			int ha;
			ha = slot_handle[a];
			place(a, slot_handle[b]);
			place(b, ha);
		endfunction

		function logic signed [31:0] wt(int slot);
			return weight_of[slot_handle[slot]];
		endfunction

		function void rise(int slot);
			int parent;
			while (slot > 0) begin
				parent = (slot - 1) / 2;
				if (wt(slot) <= wt(parent)) break;
				swap(slot, parent);
				slot = parent;
			end
		endfunction

		function void sink(int slot);
			int left;
			int pick;
			while (slot < count) begin
				left = 2 * slot + 1;
				if (left >= count) break;
				pick = left;
				if (left + 1 < count && wt(left) < wt(left + 1)) pick = left + 1;
				if (wt(slot) >= wt(pick)) break;
				swap(slot, pick);
				slot = pick;
			end
		endfunction

		// Note an accepted input beat: advance the heap and queue its result
		function void note_input(imhq_pkg::in_item_t it);
			imhq_pkg::out_item_t r;
			int h;
			r = '0;
			case (it.mode)
				imhq_pkg::MODE_PUSH: begin
					if (count >= imhq_pkg::HEAP_CAPACITY) begin
						r.status = imhq_pkg::ST_FULL;
					end else begin
						if (free_count > 0) begin
							free_count--;
							h = free_stack[free_count];
						end else begin
							h = fresh;
							fresh++;
						end
						payload_of[h] = it.value;
						weight_of[h] = it.weight;
						live[h] = 1;
						place(count, h);
						count++;
						rise(count - 1);
						r.new_handle = h[9:0];
					end
				end
				imhq_pkg::MODE_POP: begin
					if (count == 0) begin
						r.status = imhq_pkg::ST_EMPTY;
					end else begin
						h = slot_handle[0];
						r.top_value = payload_of[h];
						r.top_weight = weight_of[h];
						live[h] = 0;
						free_stack[free_count] = h;
						free_count++;
						count--;
						if (count > 0) begin
							place(0, slot_handle[count]);
							sink(0);
						end
					end
				end
				imhq_pkg::MODE_UPDATE: begin
					h = it.handle;
					if (!live[h]) begin
						r.status = imhq_pkg::ST_BAD_HANDLE;
					end else if (it.weight != weight_of[h]) begin
						if (it.weight > weight_of[h]) begin
							weight_of[h] = it.weight;
							rise(slot_of[h]);
						end else begin
							weight_of[h] = it.weight;
							sink(slot_of[h]);
						end
					end
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		// Check one accepted result beat against the oldest expectation
		task check_result(imhq_pkg::out_item_t got);
			imhq_pkg::out_item_t e;
			checked++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result beat %h", got));
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status)
				report($sformatf("status %0d, want %0d", got.status, e.status));
			if (got.new_handle !== e.new_handle)
				report($sformatf("new_handle %0d, want %0d", got.new_handle, e.new_handle));
			if (got.top_value !== e.top_value)
				report($sformatf("top_value %h, want %h", got.top_value, e.top_value));
			if (got.top_weight !== e.top_weight)
				report($sformatf("top_weight %0d, want %0d", got.top_weight, e.top_weight));
		endtask

		// Pick a live handle, or any handle if none is live
		function int some_live_handle();
			int start;
			start = $urandom_range(0, imhq_pkg::HEAP_CAPACITY - 1);
			for (int i = 0; i < imhq_pkg::HEAP_CAPACITY; i++)
				if (live[(start + i) % imhq_pkg::HEAP_CAPACITY])
					return (start + i) % imhq_pkg::HEAP_CAPACITY;
			return start;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	imhq_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	imhq_pkg::out_item_t out_data;

	heap_scoreboard sb;
	bit burst;
	int sent;
	int cycles;

	indexed_max_heap_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Count cycles and stop a hung run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offer one input beat and hold it until accepted
	task send(logic [1:0] mode, logic [31:0] value, logic signed [31:0] weight,
		logic [9:0] handle);
		imhq_pkg::in_item_t it;
		int gap;
		bit taken;
		it.mode = mode;
		it.value = value;
		it.weight = weight;
		it.handle = handle;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		sb.note_input(it);
		sent++;
	endtask

	task push(logic [31:0] value, logic signed [31:0] weight);
		send(imhq_pkg::MODE_PUSH, value, weight, '0);
	endtask

	task pop();
		send(imhq_pkg::MODE_POP, $urandom, $signed($urandom), 10'($urandom));
	endtask

	task update(logic [9:0] handle, logic signed [31:0] weight);
		send(imhq_pkg::MODE_UPDATE, $urandom, weight, handle);
	endtask

	task idle_sender();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function logic signed [31:0] rand_weight();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 7)) - 4;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom);
		endcase
	endfunction

	// Receiver: random stalls, one long hold-off to back the block up
	initial begin
		bit got;
		imhq_pkg::out_item_t beat;
		int stall;
		bit held;
		out_stall = 1'b1;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (!held && sb.checked == 40) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			stall = burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_stall <= 1'b1;
				repeat (stall) @(posedge clk);
			end
			out_stall <= 1'b0;
			got = 0;
			while (!got) begin
				@(negedge clk);
				got = out_valid;
				beat = out_data;
				@(posedge clk);
			end
			sb.check_result(beat);
		end
	end

	initial begin
		int kind;
		int waited;
		sb = new();
		sent = 0;
		burst = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, bad handles, unknown mode, extremes, ties, updates
		pop();
		update(10'd0, 32'sd5);
		update(10'd1023, 32'sd5);
		send(MODE_NONE, 32'hffffffff, 32'sh7fffffff, 10'h3ff);
		push(32'hffffffff, 32'sh7fffffff);
		push(32'h00000000, 32'sh80000000);
		push(32'h12345678, 32'sd0);
		push(32'h87654321, -32'sd1);
		push(32'h55aa55aa, 32'sd0);
		push(32'haa55aa55, 32'sd0);
		update(10'd0, 32'sh80000000);
		update(10'd1, 32'sh7fffffff);
		update(10'd2, 32'sd0);
		update(10'd3, 32'sd100);
		pop();
		pop();
		push(32'hdeadbeef, 32'sd7);
		update(10'd500, 32'sd1);
		pop();
		pop();
		pop();
		pop();
		pop();
		pop();

		// Random mix of pushes, pops, updates and unknown modes with bursts
		for (int i = 0; i < 520; i++) begin
			if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 42) push($urandom, rand_weight());
			else if (kind < 70) pop();
			else if (kind < 90) update(10'(sb.some_live_handle()), rand_weight());
			else if (kind < 96) update(10'($urandom), rand_weight());
			else send(MODE_NONE, $urandom, $signed($urandom), 10'($urandom));
		end
		burst = 0;
		idle_sender();

		// Drain outstanding results, then let the block settle
		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
		$display("sent %0d beats, checked %0d results, %0d entries left in heap",
			sent, sb.checked, sb.count);
		$display("exercised empty pops, stale handles, weight ties and moves both ways");
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/imhq_pkg.sv
hdl/indexed_max_heap_queue.sv
dv/tb_indexed_max_heap_queue.sv
